@@ hdl/drs_pkg.sv @@
//------------------------------------------------------------------------------
// Disk request scheduler package
// Item types, policy codes and widths shared by the scheduler.
//------------------------------------------------------------------------------
package drs_pkg;

   typedef enum logic [1:0] {
      POLICY_FCFS = 2'd0,
      POLICY_SSTF = 2'd1,
      POLICY_LOOK = 2'd2,
      POLICY_RSVD = 2'd3
   } policy_type;

   typedef enum logic {
      OP_ARRIVE   = 1'b0,
      OP_COMPLETE = 1'b1
   } op_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] ticket;
      logic [31:0] arrival_time;
      logic [15:0] target_cylinder;
      logic [31:0] block_address;
      logic [15:0] owner_process;
      logic [15:0] head_cylinder;
      logic        scan_up;
   } req_type;

   typedef struct packed {
      logic [31:0] serve_id;
      logic [31:0] serve_time;
      logic [15:0] serve_cylinder;
      logic [31:0] serve_address;
      logic [15:0] serve_process;
      logic        idle;
      logic        dropped;
      logic [4:0]  waiting_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] time_stamp;
      logic [15:0] cylinder;
      logic [31:0] address;
      logic [15:0] process;
   } entry_type;

endpackage

@@ hdl/disk_request_scheduler_unit.sv @@
//------------------------------------------------------------------------------
// Disk request scheduler
// Serves one disk request and queues the rest; picks the next request by
// first come first served, shortest seek or look, using one shared comparator.
//------------------------------------------------------------------------------
//  channel | direction | handshake      | payload
//  req_    | in        | valid / stall  | drs_pkg::req_type
//  rsp_    | out       | valid / stall  | drs_pkg::rsp_type
//  csr_    | in        | valid / ready  | policy, 2 bits
//
//  A completion scans the queue, one entry per cycle through the shared
//  comparator, up to three passes for look, then shifts the entries above
//  the pick down one per cycle.
//  Reset is synchronous; the queue memory needs no clearing pass.
//  A stalled result holds; no new item is taken until it has gone.
//------------------------------------------------------------------------------
module disk_request_scheduler_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  drs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output drs_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_data
);
   import drs_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_READ, S_SHIFT, S_TAKE, S_DONE
   } state_type;

   entry_type queue_mem [QUEUE_DEPTH];

   state_type   state_ff, state_in;
   policy_type  policy_ff;
   req_type     req_ff, req_in;
   entry_type   serve_ff, serve_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] k_ff, k_in;
   logic [1:0]  pass_ff, pass_in;
   logic        found_ff, found_in;
   logic [IW-1:0] best_ff, best_in;
   logic [15:0] bestd_ff, bestd_in;
   logic [31:0] bestt_ff, bestt_in;
   logic        dropped_ff, dropped_in;
   logic        valid_ff, valid_in;
   entry_type   rd_ff;
   logic        wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   entry_type   wr_data;
   logic        rd_pend_ff, rd_pend_in;

   logic [15:0] seek_gap;
   logic        cand, better;
   logic        idle_now;

   assign idle_now  = (serve_ff == '0);
   assign req_stall = (state_ff != S_IDLE) || valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = valid_ff;

   always_comb begin
      rsp_data.serve_id       = serve_ff.id;
      rsp_data.serve_time     = serve_ff.time_stamp;
      rsp_data.serve_cylinder = serve_ff.cylinder;
      rsp_data.serve_address  = serve_ff.address;
      rsp_data.serve_process  = serve_ff.process;
      rsp_data.idle           = idle_now;
      rsp_data.dropped        = dropped_ff;
      rsp_data.waiting_count  = 5'(count_ff);
   end

   // shared distance / compare unit on the entry read last cycle
   always_comb begin
      seek_gap = (rd_ff.cylinder >= req_ff.head_cylinder) ?
                 rd_ff.cylinder - req_ff.head_cylinder :
                 req_ff.head_cylinder - rd_ff.cylinder;
      cand   = 1'b1;
      better = 1'b0;
      case (policy_ff)
         POLICY_SSTF: begin
            better = !found_ff || seek_gap < bestd_ff ||
                     (seek_gap == bestd_ff && rd_ff.time_stamp < bestt_ff);
         end
         POLICY_LOOK: begin
            case (pass_ff)
               2'd0: begin
                  cand   = (seek_gap == 16'd0);
                  better = !found_ff || rd_ff.time_stamp < bestt_ff;
               end
               2'd1: begin
                  cand = req_ff.scan_up ? (rd_ff.cylinder > req_ff.head_cylinder)
                                        : (rd_ff.cylinder < req_ff.head_cylinder);
                  better = !found_ff || seek_gap < bestd_ff ||
                           (seek_gap == bestd_ff && rd_ff.time_stamp < bestt_ff);
               end
               default: begin
                  better = !found_ff || seek_gap < bestd_ff ||
                           (seek_gap == bestd_ff && rd_ff.time_stamp < bestt_ff);
               end
            endcase
         end
         default: begin
            better = !found_ff || rd_ff.time_stamp < bestt_ff;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      serve_in   = serve_ff;
      count_in   = count_ff;
      k_in       = k_ff;
      pass_in    = pass_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      bestd_in   = bestd_ff;
      bestt_in   = bestt_ff;
      dropped_in = dropped_ff;
      valid_in   = valid_ff && rsp_stall;
      rd_pend_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = k_ff[IW-1:0];
      wr_data    = rd_ff;
      rd_addr    = k_ff[IW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in     = req_data;
               dropped_in = 1'b0;
               if (req_data.operation == OP_ARRIVE) begin
                  if (idle_now) begin
                     serve_in = {req_data.ticket, req_data.arrival_time,
                                 req_data.target_cylinder, req_data.block_address,
                                 req_data.owner_process};
                  end else if (count_ff < CW'(QUEUE_DEPTH)) begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IW-1:0];
                     wr_data  = {req_data.ticket, req_data.arrival_time,
                                 req_data.target_cylinder, req_data.block_address,
                                 req_data.owner_process};
                     count_in = count_ff + 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
                  state_in = S_DONE;
               end else if (count_ff == '0) begin
                  serve_in = '0;
                  state_in = S_DONE;
               end else begin
                  k_in     = '0;
                  pass_in  = 2'd0;
                  found_in = 1'b0;
                  best_in  = '0;
                  rd_addr  = '0;
                  rd_pend_in = 1'b1;
                  k_in     = CW'(1);
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // rd_ff holds entry k_ff-1
            if (cand && better) begin
               found_in = 1'b1;
               best_in  = IW'(k_ff - 1'b1);
               bestd_in = seek_gap;
               bestt_in = rd_ff.time_stamp;
            end
            if (k_ff == count_ff) begin
               if (policy_ff == POLICY_LOOK && pass_ff != 2'd2 &&
                   !(found_ff || (cand && better))) begin
                  pass_in    = pass_ff + 1'b1;
                  rd_addr    = '0;
                  rd_pend_in = 1'b1;
                  k_in       = CW'(1);
               end else begin
                  rd_addr  = (cand && better) ? IW'(k_ff - 1'b1) : best_ff;
                  state_in = S_READ;
               end
            end else begin
               rd_addr    = k_ff[IW-1:0];
               rd_pend_in = 1'b1;
               k_in       = k_ff + 1'b1;
            end
         end
         S_READ: begin
            rd_addr  = best_ff;
            state_in = S_TAKE;
         end
         S_TAKE: begin
            serve_in = rd_ff;
            k_in     = CW'(best_ff) + 1'b1;
            rd_addr  = IW'(CW'(best_ff) + 1'b1);
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            // rd_ff holds entry k_ff; move it to k_ff-1
            if (k_ff >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               wr_en   = 1'b1;
               wr_addr = IW'(k_ff - 1'b1);
               wr_data = rd_ff;
               k_in    = k_ff + 1'b1;
               rd_addr = IW'(k_ff + 1'b1);
               state_in = S_SHIFT;
            end
         end
         S_DONE: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_mem[wr_addr] <= wr_data;
      end
      rd_ff <= queue_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         policy_ff  <= POLICY_FCFS;
         serve_ff   <= '0;
         count_ff   <= '0;
         valid_ff   <= 1'b0;
         dropped_ff <= 1'b0;
         k_ff       <= '0;
         pass_ff    <= '0;
         found_ff   <= 1'b0;
         best_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         if (csr_valid && csr_ready) begin
            policy_ff <= policy_type'(csr_data);
         end
         serve_ff   <= serve_in;
         count_ff   <= count_in;
         valid_ff   <= valid_in;
         dropped_ff <= dropped_in;
         k_ff       <= k_in;
         pass_ff    <= pass_in;
         found_ff   <= found_in;
         best_ff    <= best_in;
         rd_pend_ff <= rd_pend_in;
      end
      req_ff   <= req_in;
      bestd_ff <= bestd_in;
      bestt_ff <= bestt_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("item taken while busy");
   a_scan_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> rd_pend_ff)
      else $error("scan without entry read");
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && dropped_ff) |-> count_ff == CW'(QUEUE_DEPTH))
      else $error("drop with room in queue");

endmodule
